FILE: rtl/core/ftf_pkg.sv
// ============================================================================
// ftf_pkg
// Shared types, constants and the microcode table of the finger sensor
// telemetry framer.
// ============================================================================
`default_nettype none

package ftf_pkg;

    localparam int SampleW = 10;
    localparam int GainW   = 11;
    localparam int OffsetW = 10;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 11;
    localparam int DiffW   = 11;
    localparam int ProdW   = 22;
    localparam int MagW    = 20;
    localparam int BcdDigits = 7;
    localparam int BcdW    = 4 * BcdDigits;
    localparam int StepW   = 4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_INDEX_GAIN    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MIDDLE_GAIN   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RING_GAIN     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LITTLE_GAIN   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_INDEX_OFFSET  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MIDDLE_OFFSET = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_RING_OFFSET   = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_LITTLE_OFFSET = 3'd7;

    localparam logic signed [GainW-1:0] GAIN_RST [4] =
        '{-11'sd284, -11'sd341, -11'sd300, 11'sd450};
    localparam logic [OffsetW-1:0] OFFSET_RST [4] =
        '{10'd711, 10'd750, 10'd638, 10'd802};

    // Channel rotation.
    localparam logic [2:0] SLOT_IGNORED = 3'd0;
    localparam logic [2:0] SLOT_THUMB   = 3'd5;

    // Thumb level codes.
    localparam logic [1:0] TL_NONE = 2'd0;
    localparam logic [1:0] TL_110  = 2'd1;
    localparam logic [1:0] TL_130  = 2'd2;
    localparam logic [1:0] TL_140  = 2'd3;

    localparam logic [SampleW-1:0] THUMB_LOW_LIM  = 10'd500;
    localparam logic [SampleW-1:0] THUMB_HIGH_LIM = 10'd800;

    // ASCII codes of the frame.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // Digit positions of the decimal word that are sent. The two lowest
    // digits are dropped, which is the division by one hundred.
    localparam logic [2:0] DIG_FIRST = 3'd6;
    localparam logic [2:0] DIG_LAST  = 3'd2;
    localparam logic [4:0] BCD_LAST_ITER = 5'(MagW - 1);

    typedef logic [StepW-1:0] step_t;

    localparam step_t STEP_WAIT  = 4'd0;
    localparam step_t STEP_MUL   = 4'd1;
    localparam step_t STEP_ABS   = 4'd2;
    localparam step_t STEP_BCD   = 4'd3;
    localparam step_t STEP_STAR  = 4'd4;
    localparam step_t STEP_LTR   = 4'd5;
    localparam step_t STEP_MINUS = 4'd6;
    localparam step_t STEP_DIGIT = 4'd7;
    localparam step_t STEP_BAR   = 4'd8;
    localparam step_t STEP_THUMB = 4'd9;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WAIT,
        OP_MUL,
        OP_ABS,
        OP_THUMB,
        OP_BCD,
        OP_DIGIT
    } op_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_STAR,
        EM_LETTER,
        EM_MINUS,
        EM_DIGIT,
        EM_BAR
    } emit_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_BCD_LOOP,
        JMP_DIGIT_LOOP
    } jmp_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FINGER,
        KIND_THUMB
    } kind_t;

    typedef struct packed {
        op_t   op;
        emit_t emit;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    // Sequencer to datapath.
    typedef struct packed {
        op_t   op;
        emit_t emit;
        logic  fire;
        logic  load_out;
        logic  in_ready;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic  accept;
        kind_t kind;
        logic  bcd_last;
        logic  need_minus;
        logic  skip_digit;
        logic  digit_last;
        logic  out_free;
    } stat_t;

    // Microcode store.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        case (step)
            STEP_WAIT:  w = '{OP_WAIT,  EM_NONE,   JMP_DISPATCH,   STEP_THUMB};
            STEP_MUL:   w = '{OP_MUL,   EM_NONE,   JMP_NEXT,       STEP_WAIT};
            STEP_ABS:   w = '{OP_ABS,   EM_NONE,   JMP_NEXT,       STEP_WAIT};
            STEP_BCD:   w = '{OP_BCD,   EM_NONE,   JMP_BCD_LOOP,   STEP_WAIT};
            STEP_STAR:  w = '{OP_NONE,  EM_STAR,   JMP_NEXT,       STEP_WAIT};
            STEP_LTR:   w = '{OP_NONE,  EM_LETTER, JMP_NEXT,       STEP_WAIT};
            STEP_MINUS: w = '{OP_NONE,  EM_MINUS,  JMP_NEXT,       STEP_WAIT};
            STEP_DIGIT: w = '{OP_DIGIT, EM_DIGIT,  JMP_DIGIT_LOOP, STEP_WAIT};
            STEP_BAR:   w = '{OP_NONE,  EM_BAR,    JMP_GOTO,       STEP_WAIT};
            STEP_THUMB: w = '{OP_THUMB, EM_NONE,   JMP_GOTO,       STEP_BCD};
            default:    w = '{OP_NONE,  EM_NONE,   JMP_GOTO,       STEP_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [1:0] thumb_code(input logic [SampleW-1:0] s);
        logic [1:0] c;
        if (s < THUMB_LOW_LIM) begin
            c = TL_110;
        end
        else if (s <= THUMB_HIGH_LIM) begin
            c = TL_130;
        end
        else begin
            c = TL_140;
        end
        return c;
    endfunction

    // Level times one hundred, so the thumb shares the finger digit path.
    function automatic logic [MagW-1:0] thumb_mag(input logic [1:0] code);
        logic [MagW-1:0] m;
        case (code)
            TL_110:  m = 20'd11000;
            TL_130:  m = 20'd13000;
            TL_140:  m = 20'd14000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ftf_ifs.sv
// ============================================================================
// ftf_ifs
// Valid/ready channels of the framer: sample words in, text words out.
// ============================================================================
`default_nettype none

interface ftf_sample_if;
    logic                        valid;
    logic                        ready;
    logic [ftf_pkg::SampleW-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ftf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       frame_end;

    modport source (output valid, output text_byte, output frame_end, input ready);
    modport sink   (input valid, input text_byte, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ftf_seq.sv
// ============================================================================
// ftf_seq
// Microcode sequencer: step counter, control store lookup and jump logic.
// ============================================================================
`default_nettype none

module ftf_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ftf_pkg::stat_t stat,
    output ftf_pkg::ctrl_t      ctrl
);

    ftf_pkg::step_t  step_reg;
    ftf_pkg::step_t  step_next;
    ftf_pkg::uword_t uw;
    logic            emit_want;
    logic            go;

    assign uw = ftf_pkg::ucode(step_reg);

    // A conditional word that is not needed retires without waiting.
    always_comb
    begin
        emit_want = (uw.emit != ftf_pkg::EM_NONE);
        if (uw.emit == ftf_pkg::EM_MINUS && !stat.need_minus) begin
            emit_want = 1'b0;
        end
        if (uw.emit == ftf_pkg::EM_DIGIT && stat.skip_digit) begin
            emit_want = 1'b0;
        end
        go = !emit_want || stat.out_free;
    end

    always_comb
    begin
        step_next = step_reg;
        case (uw.jmp)
            ftf_pkg::JMP_NEXT:
            begin
                if (go) begin
                    step_next = step_reg + 1'b1;
                end
            end
            ftf_pkg::JMP_GOTO:
            begin
                if (go) begin
                    step_next = uw.target;
                end
            end
            ftf_pkg::JMP_DISPATCH:
            begin
                if (stat.accept) begin
                    case (stat.kind)
                        ftf_pkg::KIND_FINGER: step_next = step_reg + 1'b1;
                        ftf_pkg::KIND_THUMB:  step_next = uw.target;
                        default:              step_next = step_reg;
                    endcase
                end
            end
            ftf_pkg::JMP_BCD_LOOP:
            begin
                if (stat.bcd_last) begin
                    step_next = step_reg + 1'b1;
                end
            end
            ftf_pkg::JMP_DIGIT_LOOP:
            begin
                if (go && stat.digit_last) begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: step_next = ftf_pkg::STEP_WAIT;
        endcase
    end

    always_comb
    begin
        ctrl.op       = uw.op;
        ctrl.emit     = uw.emit;
        ctrl.fire     = go;
        ctrl.load_out = emit_want && stat.out_free;
        ctrl.in_ready = (uw.op == ftf_pkg::OP_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= ftf_pkg::STEP_WAIT;
        end
        else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ftf_dp.sv
// ============================================================================
// ftf_dp
// Datapath: gain and offset registers, slot rotation, multiplier, binary to
// decimal shifter and the output word register.
// ============================================================================
`default_nettype none

module ftf_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ftf_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [ftf_pkg::CfgW-1:0]      cfg_data,
    input  wire logic                          in_valid,
    input  wire logic [ftf_pkg::SampleW-1:0]   in_sample,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [7:0]                         out_byte,
    output logic                               out_end,
    input  wire ftf_pkg::ctrl_t                ctrl,
    output ftf_pkg::stat_t                     stat
);

    logic signed [ftf_pkg::GainW-1:0]   gain_reg   [4];
    logic signed [ftf_pkg::GainW-1:0]   gain_next  [4];
    logic        [ftf_pkg::OffsetW-1:0] offset_reg [4];
    logic        [ftf_pkg::OffsetW-1:0] offset_next[4];

    logic [2:0] slot_reg, slot_next;
    logic [1:0] last_reg, last_next;

    logic        [1:0]                finger_reg, finger_next;
    logic        [1:0]                code_reg, code_next;
    logic        [7:0]                letter_reg, letter_next;
    logic signed [ftf_pkg::DiffW-1:0] diff_reg, diff_next;
    logic signed [ftf_pkg::ProdW-1:0] prod_reg, prod_next;
    logic                             neg_reg, neg_next;
    logic        [ftf_pkg::MagW-1:0]  sh_reg, sh_next;
    logic        [ftf_pkg::BcdW-1:0]  bcd_reg, bcd_next;
    logic        [4:0]                bcnt_reg, bcnt_next;
    logic        [2:0]                dig_reg, dig_next;
    logic                             started_reg, started_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_end_reg, out_end_next;

    logic                             accept;
    logic [1:0]                       fsel;
    logic [1:0]                       in_code;
    ftf_pkg::kind_t                   kind;
    logic        [ftf_pkg::BcdW-1:0]  bcd_adj;
    logic signed [ftf_pkg::ProdW-1:0] prod_abs;
    logic        [3:0]                digit;
    logic                             out_free;

    assign accept  = in_valid && ctrl.in_ready;
    // Slots one to four map onto fingers zero to three.
    assign fsel    = slot_reg[1:0] - 2'd1;
    assign in_code = ftf_pkg::thumb_code(in_sample);
    assign digit   = bcd_reg[{dig_reg, 2'b00} +: 4];
    assign prod_abs = prod_reg[ftf_pkg::ProdW-1] ? -prod_reg : prod_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (slot_reg >= 3'd1 && slot_reg <= 3'd4) begin
            kind = ftf_pkg::KIND_FINGER;
        end
        else if (slot_reg == ftf_pkg::SLOT_THUMB && in_code != last_reg) begin
            kind = ftf_pkg::KIND_THUMB;
        end
        else begin
            kind = ftf_pkg::KIND_NONE;
        end
    end

    // Add-three adjust of every decimal digit ahead of the shift.
    always_comb
    begin
        for (int i = 0; i < ftf_pkg::BcdDigits; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        stat.accept     = accept;
        stat.kind       = kind;
        stat.bcd_last   = (bcnt_reg == ftf_pkg::BCD_LAST_ITER);
        stat.need_minus = neg_reg && (bcd_reg[ftf_pkg::BcdW-1:8] != '0);
        stat.skip_digit = !started_reg && (digit == 4'd0) && (dig_reg != ftf_pkg::DIG_LAST);
        stat.digit_last = (dig_reg == ftf_pkg::DIG_LAST);
        stat.out_free   = out_free;
    end

    always_comb
    begin
        gain_next    = gain_reg;
        offset_next  = offset_reg;
        slot_next    = slot_reg;
        last_next    = last_reg;
        finger_next  = finger_reg;
        code_next    = code_reg;
        letter_next  = letter_reg;
        diff_next    = diff_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        sh_next      = sh_reg;
        bcd_next     = bcd_reg;
        bcnt_next    = bcnt_reg;
        dig_next     = dig_reg;
        started_next = started_reg;

        if (cfg_wr_en) begin
            if (cfg_index[2] == 1'b0) begin
                gain_next[cfg_index[1:0]] = cfg_data;
            end
            else begin
                offset_next[cfg_index[1:0]] = cfg_data[ftf_pkg::OffsetW-1:0];
            end
        end

        case (ctrl.op)
            ftf_pkg::OP_WAIT:
            begin
                if (accept) begin
                    finger_next = fsel;
                    code_next   = in_code;
                    diff_next   = $signed({1'b0, in_sample}) - $signed({1'b0, offset_reg[fsel]});
                    if (kind == ftf_pkg::KIND_THUMB) begin
                        letter_next = ftf_pkg::CH_E;
                    end
                    else begin
                        letter_next = ftf_pkg::CH_A + {6'd0, fsel};
                    end
                    if (slot_reg == ftf_pkg::SLOT_THUMB) begin
                        last_next = in_code;
                    end
                    if (slot_reg >= ftf_pkg::SLOT_THUMB) begin
                        slot_next = ftf_pkg::SLOT_IGNORED;
                    end
                    else begin
                        slot_next = slot_reg + 3'd1;
                    end
                end
            end
            ftf_pkg::OP_MUL:
            begin
                prod_next = gain_reg[finger_reg] * diff_reg;
            end
            ftf_pkg::OP_ABS:
            begin
                neg_next     = prod_reg[ftf_pkg::ProdW-1];
                sh_next      = prod_abs[ftf_pkg::MagW-1:0];
                bcd_next     = '0;
                bcnt_next    = '0;
                dig_next     = ftf_pkg::DIG_FIRST;
                started_next = 1'b0;
            end
            ftf_pkg::OP_THUMB:
            begin
                neg_next     = 1'b0;
                sh_next      = ftf_pkg::thumb_mag(code_reg);
                bcd_next     = '0;
                bcnt_next    = '0;
                dig_next     = ftf_pkg::DIG_FIRST;
                started_next = 1'b0;
            end
            ftf_pkg::OP_BCD:
            begin
                bcd_next  = {bcd_adj[ftf_pkg::BcdW-2:0], sh_reg[ftf_pkg::MagW-1]};
                sh_next   = {sh_reg[ftf_pkg::MagW-2:0], 1'b0};
                bcnt_next = bcnt_reg + 5'd1;
            end
            ftf_pkg::OP_DIGIT:
            begin
                if (ctrl.fire) begin
                    dig_next = dig_reg - 3'd1;
                    if (!stat.skip_digit) begin
                        started_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        if (ctrl.load_out) begin
            out_valid_next = 1'b1;
            out_end_next   = (ctrl.emit == ftf_pkg::EM_BAR);
            case (ctrl.emit)
                ftf_pkg::EM_STAR:   out_byte_next = ftf_pkg::CH_STAR;
                ftf_pkg::EM_LETTER: out_byte_next = letter_reg;
                ftf_pkg::EM_MINUS:  out_byte_next = ftf_pkg::CH_MINUS;
                ftf_pkg::EM_DIGIT:  out_byte_next = {ftf_pkg::CH_DIGIT_HI, digit};
                ftf_pkg::EM_BAR:    out_byte_next = ftf_pkg::CH_BAR;
                default:            out_byte_next = ftf_pkg::CH_STAR;
            endcase
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gain_reg      <= ftf_pkg::GAIN_RST;
            offset_reg    <= ftf_pkg::OFFSET_RST;
            slot_reg      <= ftf_pkg::SLOT_IGNORED;
            last_reg      <= ftf_pkg::TL_NONE;
            out_valid_reg <= 1'b0;
        end
        else begin
            gain_reg      <= gain_next;
            offset_reg    <= offset_next;
            slot_reg      <= slot_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        finger_reg   <= finger_next;
        code_reg     <= code_next;
        letter_reg   <= letter_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        sh_reg       <= sh_next;
        bcd_reg      <= bcd_next;
        bcnt_reg     <= bcnt_next;
        dig_reg      <= dig_next;
        started_reg  <= started_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;

endmodule

`default_nettype wire

FILE: rtl/core/finger_sensor_telemetry_framer_top.sv
// ============================================================================
// finger_sensor_telemetry_framer_top
// Turns a six-slot rotation of ADC samples into ASCII finger telemetry.
// ============================================================================
// The block takes one sample word when it is waiting and then works on that
// sample alone. A sample in slot 0, or a thumb sample whose level did not
// change, makes no frame and leaves the block waiting. A finger sample is
// taken, multiplied and made a magnitude, goes through the binary to decimal
// shift loop over the 20 magnitude bits, then a step for each of the nine
// frame positions (a skipped sign or leading zero still has its step). A
// changed thumb level joins that path at the shift loop after the thumb step.
// Stalls on the text channel hold the sequencer at a frame position with a
// byte to send. The output word sits in a register, so the next word is
// prepared while the last waits to be taken. The slot counter starts at 0
// after reset. Gains and offsets are to be written through the plain write
// port while the block is idle; the block itself does not enforce this.
`default_nettype none

module finger_sensor_telemetry_framer_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ftf_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [ftf_pkg::CfgW-1:0]    cfg_data,
    ftf_sample_if.sink                       sample_ch,
    ftf_text_if.source                       text_ch
);

    ftf_pkg::ctrl_t ctrl;
    ftf_pkg::stat_t stat;

    assign sample_ch.ready = ctrl.in_ready;

    ftf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    ftf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (sample_ch.valid),
        .in_sample (sample_ch.sample),
        .out_ready (text_ch.ready),
        .out_valid (text_ch.valid),
        .out_byte  (text_ch.text_byte),
        .out_end   (text_ch.frame_end),
        .ctrl      (ctrl),
        .stat      (stat)
    );

`ifndef SYNTH
    // A word is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> stat.out_free)
        else $error("output word overwritten");

    // A sample that produces no frame leaves the block waiting.
    a_quiet_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.accept && stat.kind == ftf_pkg::KIND_NONE) |=> ctrl.in_ready)
        else $error("quiet sample left the sequencer busy");

    // A sample that produces a frame blocks further input until its closing byte is loaded for output.
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.accept && stat.kind != ftf_pkg::KIND_NONE) |=> !ctrl.in_ready)
        else $error("input taken while a frame is pending");

    // The closing byte only comes out of the end-of-frame step.
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> (text_ch.frame_end == $past(ctrl.emit == ftf_pkg::EM_BAR)))
        else $error("frame end marker mismatch");
`endif

endmodule

`default_nettype wire
